// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker modules
// each macro expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int SPQ_CAPACITY    = 256;
    localparam int SPQ_KEY_BITS    = 32;
    localparam int SPQ_HANDLE_BITS = 16;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } spq_status_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } spq_op_t;

    // per-cell position relative to the fill level
    typedef struct packed {
        logic occ;
        logic at_end;
    } spq_slot_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted chain, slot 0 holds the smallest key
// depends on spq_pkg
`default_nettype none

module spq_cell #(
    parameter int KEY_BITS    = spq_pkg::SPQ_KEY_BITS,
    parameter int HANDLE_BITS = spq_pkg::SPQ_HANDLE_BITS
) (
    input  wire                      clk,
    input  wire spq_pkg::spq_op_t    op,
    input  wire spq_pkg::spq_slot_t  slot,
    input  wire [KEY_BITS-1:0]       new_key,
    input  wire [HANDLE_BITS-1:0]    new_handle,
    input  wire                      lower_up,
    input  wire [KEY_BITS-1:0]       lower_key,
    input  wire [HANDLE_BITS-1:0]    lower_handle,
    input  wire [KEY_BITS-1:0]       upper_key,
    input  wire [HANDLE_BITS-1:0]    upper_handle,
    output logic                     up,
    output logic [KEY_BITS-1:0]      cell_key,
    output logic [HANDLE_BITS-1:0]   cell_handle
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0]    key_reg;
    logic [KEY_BITS-1:0]    key_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;

    // entry moves up on insert when its key is not below the new key
    assign up          = slot.occ && (key_reg >= new_key);
    assign cell_key    = key_reg;
    assign cell_handle = handle_reg;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (op.pop)
        begin
            key_next    = upper_key;
            handle_next = upper_handle;
        end
        else if (op.push)
        begin
            if (lower_up)
            begin
                key_next    = lower_key;
                handle_next = lower_handle;
            end
            else if (up || slot.at_end)
            begin
                key_next    = new_key;
                handle_next = new_handle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// top level of the sorted priority queue: fill counter, result beat and the cell chain
// depends on spq_pkg and spq_cell
//
// usage
//   command channel: start with mode, key and handle; a beat is taken at a rising
//   edge with start high and busy low. busy stays low, so a command may be issued
//   in every cycle.
//   result channel: done is high for exactly one cycle with out_key, out_handle,
//   status and fill; the receiver cannot hold it off.
//   each result is registered and appears in the cycle after its command is taken.
//   throughput: one command per cycle. every cell compares its key against the
//   new key and picks its next value in that single cycle, so the cell compare
//   and the fill-level decode set the clock period.
//   push: takes the slot of the first entry whose key is not below it; equal keys
//   leave the newest nearest cell 0. a push when full is dropped (overflow).
//   pop: returns the smallest key, held in cell 0; a pop when empty reports
//   underflow. out_key and out_handle are zero unless a pop succeeds.
//   fill is the entry count after the command.
//   reset clears the count, done and status; cell contents are left as they are and
//   are never read before being written.
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY    = spq_pkg::SPQ_CAPACITY,
    parameter int KEY_BITS    = spq_pkg::SPQ_KEY_BITS,
    parameter int HANDLE_BITS = spq_pkg::SPQ_HANDLE_BITS,
    parameter int FILL_BITS   = $clog2(CAPACITY + 1)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire                     mode,
    input  wire [KEY_BITS-1:0]      key,
    input  wire [HANDLE_BITS-1:0]   handle,
    output logic                    done,
    output logic [KEY_BITS-1:0]     out_key,
    output logic [HANDLE_BITS-1:0]  out_handle,
    output logic [1:0]              status,
    output logic [FILL_BITS-1:0]    fill
);
    import spq_pkg::*;

    localparam logic [FILL_BITS-1:0] FULL_COUNT = FILL_BITS'(CAPACITY);

    logic [FILL_BITS-1:0]   count_reg;
    logic [FILL_BITS-1:0]   count_next;
    logic                   done_reg;
    spq_status_t            status_reg;
    spq_status_t            status_next;
    logic [KEY_BITS-1:0]    out_key_reg;
    logic [KEY_BITS-1:0]    out_key_next;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [HANDLE_BITS-1:0] out_handle_next;

    logic    accept;
    spq_op_t op;

    logic [KEY_BITS-1:0]    cell_key    [CAPACITY];
    logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
    logic                   cell_up     [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        op              = '0;
        count_next      = count_reg;
        status_next     = ST_OK;
        out_key_next    = '0;
        out_handle_next = '0;
        if (accept)
        begin
            if (mode == MODE_PUSH)
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    op.push    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    op.pop          = 1'b1;
                    count_next      = count_reg - 1'b1;
                    out_key_next    = cell_key[0];
                    out_handle_next = cell_handle[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_key_reg    <= out_key_next;
            out_handle_reg <= out_handle_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_key    = out_key_reg;
    assign out_handle = out_handle_reg;
    assign fill       = count_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_slot_t              slot;
        logic                   lower_up;
        logic [KEY_BITS-1:0]    lower_key;
        logic [HANDLE_BITS-1:0] lower_handle;
        logic [KEY_BITS-1:0]    upper_key;
        logic [HANDLE_BITS-1:0] upper_handle;

        assign slot.occ    = FILL_BITS'(i) < count_reg;
        assign slot.at_end = FILL_BITS'(i) == count_reg;

        if (i == 0)
        begin : g_first
            assign lower_up     = 1'b0;
            assign lower_key    = '0;
            assign lower_handle = '0;
        end
        else
        begin : g_inner_lo
            assign lower_up     = cell_up[i-1];
            assign lower_key    = cell_key[i-1];
            assign lower_handle = cell_handle[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_key    = '0;
            assign upper_handle = '0;
        end
        else
        begin : g_inner_hi
            assign upper_key    = cell_key[i+1];
            assign upper_handle = cell_handle[i+1];
        end

        spq_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk          (clk),
            .op           (op),
            .slot         (slot),
            .new_key      (key),
            .new_handle   (handle),
            .lower_up     (lower_up),
            .lower_key    (lower_key),
            .lower_handle (lower_handle),
            .upper_key    (upper_key),
            .upper_handle (upper_handle),
            .up           (cell_up[i]),
            .cell_key     (cell_key[i]),
            .cell_handle  (cell_handle[i])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module spq_checker #(
    parameter int CAPACITY  = spq_pkg::SPQ_CAPACITY,
    parameter int KEY_BITS  = spq_pkg::SPQ_KEY_BITS,
    parameter int FILL_BITS = $clog2(CAPACITY + 1)
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  start,
    input wire                  busy,
    input wire                  mode,
    input wire                  done,
    input wire [KEY_BITS-1:0]   out_key,
    input wire [1:0]            status,
    input wire [FILL_BITS-1:0]  fill
);
    import spq_pkg::*;

    `SPQ_ASSERT_NEXT(a_beat_gives_result, start && !busy, done)
    `SPQ_ASSERT_NEXT(a_no_spurious_result, !(start && !busy), !done)
    `SPQ_ASSERT_NOW(a_underflow_empty, done && status == ST_UNDERFLOW,
        fill == '0 && out_key == '0)
    `SPQ_ASSERT_NOW(a_overflow_full, done && status == ST_OVERFLOW,
        fill == FILL_BITS'(CAPACITY))
    `SPQ_ASSERT_NOW(a_push_grows, done && status == ST_OK && $past(mode) == MODE_PUSH,
        fill == FILL_BITS'($past(fill) + 1'b1))

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .FILL_BITS (FILL_BITS)
) u_spq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .mode    (mode),
    .done    (done),
    .out_key (out_key),
    .status  (status),
    .fill    (fill)
);

`default_nettype wire

// ===== bench/sorted_priority_queue_tb.sv =====
// self-checking bench for sorted_priority_queue: directed and random push/pop beats
// checked against a sorted-queue predictor in the bench
// depends on spq_pkg and the sorted_priority_queue rtl
`default_nettype none

module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAP        = SPQ_CAPACITY;
    localparam int KB         = SPQ_KEY_BITS;
    localparam int HB         = SPQ_HANDLE_BITS;
    localparam int FB         = $clog2(CAP + 1);
    localparam int TAIL_ITEMS = 60;

    typedef struct {
        logic          op;
        logic [KB-1:0] key;
        logic [HB-1:0] handle;
    } cmd_t;

    typedef struct {
        logic [KB-1:0] key;
        logic [HB-1:0] handle;
    } entry_t;

    typedef struct {
        logic [KB-1:0] out_key;
        logic [HB-1:0] out_handle;
        spq_status_t   status;
        logic [FB-1:0] fill;
    } reply_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          mode = MODE_PUSH;
    logic [KB-1:0] key = '0;
    logic [HB-1:0] handle = '0;
    wire           busy;
    wire           done;
    wire  [KB-1:0] out_key;
    wire  [HB-1:0] out_handle;
    wire  [1:0]    status;
    wire  [FB-1:0] fill;

    cmd_t   cmd_backlog[$];
    reply_t awaited_replies[$];
    entry_t queue_entries[$];
    int     n_total;
    int     n_taken;
    int     gap_left;
    int     gen_fill;
    int     n_fail;

    sorted_priority_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .key        (key),
        .handle     (handle),
        .done       (done),
        .out_key    (out_key),
        .out_handle (out_handle),
        .status     (status),
        .fill       (fill)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // entries kept largest key first, tail is popped
    function automatic reply_t apply_queue_op(cmd_t c);
        reply_t r;
        entry_t e;
        int     pos;
        r.out_key    = '0;
        r.out_handle = '0;
        r.status     = ST_OK;
        if (c.op == MODE_PUSH)
        begin
            if (queue_entries.size() >= CAP)
            begin
                r.status = ST_OVERFLOW;
            end
            else
            begin
                pos = queue_entries.size();
                for (int i = 0; i < queue_entries.size(); i++)
                begin
                    if (queue_entries[i].key < c.key)
                    begin
                        pos = i;
                        break;
                    end
                end
                e.key    = c.key;
                e.handle = c.handle;
                queue_entries.insert(pos, e);
            end
        end
        else
        begin
            if (queue_entries.size() == 0)
            begin
                r.status = ST_UNDERFLOW;
            end
            else
            begin
                e            = queue_entries.pop_back();
                r.out_key    = e.key;
                r.out_handle = e.handle;
            end
        end
        r.fill = FB'(queue_entries.size());
        return r;
    endfunction

    function automatic void add_cmd(logic op, logic [KB-1:0] k, logic [HB-1:0] h);
        cmd_t c;
        c.op     = op;
        c.key    = k;
        c.handle = h;
        cmd_backlog.push_back(c);
        if (op == MODE_PUSH && gen_fill < CAP)
            gen_fill++;
        else if (op == MODE_POP && gen_fill > 0)
            gen_fill--;
    endfunction

    // narrow keys make ties common
    function automatic logic [KB-1:0] rand_key();
        case ($urandom_range(0, 3))
            0:       return KB'($urandom_range(0, 15));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return KB'($urandom);
        endcase
    endfunction

    function automatic void add_random(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            add_cmd(MODE_PUSH, rand_key(), HB'($urandom));
        else
            add_cmd(MODE_POP, KB'($urandom), HB'($urandom));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_replies.push_back(apply_queue_op(cmd_backlog[0]));
                void'(cmd_backlog.pop_front());
                n_taken++;
            end
            if (!(start && busy))
            begin
                if (gap_left == 0 && n_taken < n_total - TAIL_ITEMS
                    && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 7);
                if (gap_left > 0 || cmd_backlog.size() == 0)
                begin
                    start  <= 1'b0;
                    mode   <= 1'($urandom);
                    key    <= KB'($urandom);
                    handle <= HB'($urandom);
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    start  <= 1'b1;
                    mode   <= cmd_backlog[0].op;
                    key    <= cmd_backlog[0].key;
                    handle <= cmd_backlog[0].handle;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        reply_t want;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result beat with nothing awaited");
                n_fail++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (out_key !== want.out_key)
                begin
                    $error("out_key: expected %h, got %h", want.out_key, out_key);
                    n_fail++;
                end
                if (out_handle !== want.out_handle)
                begin
                    $error("out_handle: expected %h, got %h", want.out_handle, out_handle);
                    n_fail++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_fail++;
                end
                if (fill !== want.fill)
                begin
                    $error("fill: expected %0d, got %0d", want.fill, fill);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        n_taken  = 0;
        n_fail   = 0;
        gen_fill = 0;
        gap_left = 0;

        // underflow, extremes, ties, drain past empty
        add_cmd(MODE_POP, '1, '1);
        add_cmd(MODE_PUSH, '0, '0);
        add_cmd(MODE_PUSH, '1, '1);
        add_cmd(MODE_PUSH, 32'd5, 16'h0001);
        add_cmd(MODE_PUSH, 32'd5, 16'h0002);
        add_cmd(MODE_PUSH, 32'd5, 16'h0003);
        add_cmd(MODE_PUSH, 32'd7, 16'haaaa);
        add_cmd(MODE_PUSH, 32'd3, 16'h5555);
        repeat (8)
            add_cmd(MODE_POP, KB'($urandom), HB'($urandom));
        add_cmd(MODE_PUSH, 32'h8000_0001, 16'h1234);
        add_cmd(MODE_POP, '0, '0);

        repeat (60)
            add_random(55);
        while (gen_fill < CAP)
            add_random(97);
        repeat (5)
            add_cmd(MODE_PUSH, rand_key(), HB'($urandom));
        repeat (10)
            add_random(50);
        while (gen_fill > 0)
            add_random(3);
        repeat (3)
            add_cmd(MODE_POP, KB'($urandom), HB'($urandom));
        repeat (40)
            add_random(60);
        n_total = cmd_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400us;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
